### sv/lennard_jones_pair_force_defines.svh
// Assertion macros used by the checker of the pair force block.
// Depends on nothing; include by bare file name.
`ifndef LENNARD_JONES_PAIR_FORCE_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_DEFINES_SVH

// Concurrent check that is off while reset is asserted.
`define LJPF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that holds in every cycle, reset included.
`define LJPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/ljpf_pkg.sv
// Types and constants of the Lennard-Jones pair force pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package ljpf_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;
    localparam int CFG_W  = 24;
    localparam int CIDX_W = 2;
    localparam int R2_W   = 48;
    localparam int Q_W    = 56;
    localparam int MUL_W  = 58;
    localparam int HALF_W = MUL_W / 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DVD_W  = Q_W + R2_W;

    localparam logic [Q_W-1:0] STAGE_MAX = {Q_W{1'b1}};
    localparam logic [CFG_W-1:0] CFG_RESET = 24'd65536;

    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = Q_W + 1;
    localparam int LATENCY = 5 + 2 * DIV_LAT + 8 * MUL_LAT;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WELL_DEPTH    = 2'd0,
        CFG_ZERO_DISTANCE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
        logic signed [IN_W-1:0] dz;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic signed [OUT_W-1:0] energy;
        logic                    too_close;
        logic                    saturated;
    } t_result;

    // Per-pair context that rides along the arithmetic units.
    typedef struct packed {
        logic [2:0][IN_W-1:0] mag;
        logic [2:0]           neg;
        logic [R2_W-1:0]      r2;
        logic                 zero;
        logic                 clip;
        logic [Q_W-1:0]       u;
        logic [Q_W-1:0]       u3;
        logic                 eneg;
        logic [Q_W-1:0]       ediff;
        logic                 gneg;
        logic [Q_W:0]         gmag;
        logic [Q_W-1:0]       emag;
        logic [Q_W-1:0]       w;
        logic [Q_W-1:0]       fmag_x;
        logic [Q_W-1:0]       fmag_y;
    } t_ctx;

endpackage

`default_nettype wire

### sv/ljpf_mul.sv
// Two-stage fixed point multiplier: floor(a*b / 2^FRAC_BITS), clipped to 56 bits.
// Depends on ljpf_pkg for widths and the context type.
`default_nettype none

module ljpf_mul #(
    parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [ljpf_pkg::MUL_W-1:0]    i_a,
    input  wire logic [ljpf_pkg::MUL_W-1:0]    i_b,
    input  wire ljpf_pkg::t_ctx                i_ctx,
    output logic                               o_vld,
    output logic [ljpf_pkg::Q_W-1:0]           o_p,
    output logic                               o_clip,
    output ljpf_pkg::t_ctx                     o_ctx
);

    localparam int H = ljpf_pkg::HALF_W;
    localparam int W = ljpf_pkg::MUL_W;
    localparam int P = ljpf_pkg::PROD_W;
    localparam int Q = ljpf_pkg::Q_W;

    logic           r_vld1;
    logic [W-1:0]   r_p00, r_p01, r_p10, r_p11;
    ljpf_pkg::t_ctx r_ctx1;

    logic [P-1:0]   n_sum;
    logic           n_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
    end

    // partial products of the 29-bit halves
    always_ff @(posedge i_clk) begin
        r_p00  <= i_a[H-1:0] * i_b[H-1:0];
        r_p01  <= i_a[H-1:0] * i_b[W-1:H];
        r_p10  <= i_a[W-1:H] * i_b[H-1:0];
        r_p11  <= i_a[W-1:H] * i_b[W-1:H];
        r_ctx1 <= i_ctx;
    end

    always_comb begin
        n_sum = {{(P-W){1'b0}}, r_p00}
              + (({{(P-W){1'b0}}, r_p01} + {{(P-W){1'b0}}, r_p10}) << H)
              + ({{(P-W){1'b0}}, r_p11} << W);
        n_clip = |n_sum[P-1:Q+FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        o_p    <= n_clip ? ljpf_pkg::STAGE_MAX : n_sum[Q+FRAC_BITS-1:FRAC_BITS];
        o_clip <= n_clip;
        o_ctx  <= r_ctx1;
    end

endmodule

`default_nettype wire

### sv/ljpf_div.sv
// Pipelined restoring divider: floor(n * 2^SHIFT / d), clipped to 56 bits.
// One overflow check stage, then one quotient bit per stage. Depends on ljpf_pkg.
`default_nettype none

module ljpf_div #(
    parameter int SHIFT = ljpf_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [ljpf_pkg::Q_W-1:0]      i_n,
    input  wire logic [ljpf_pkg::R2_W-1:0]     i_d,
    input  wire ljpf_pkg::t_ctx                i_ctx,
    output logic                               o_vld,
    output logic [ljpf_pkg::Q_W-1:0]           o_q,
    output logic                               o_clip,
    output ljpf_pkg::t_ctx                     o_ctx
);

    localparam int Q  = ljpf_pkg::Q_W;
    localparam int D  = ljpf_pkg::R2_W;
    localparam int NW = ljpf_pkg::DVD_W;

    logic [NW-1:0]  n_num;

    logic [Q:0]     r_vld;
    logic [D-1:0]   r_rem  [0:Q];
    logic [D-1:0]   r_d    [0:Q];
    logic [Q-1:0]   r_low  [0:Q];
    logic [Q-1:0]   r_q    [0:Q];
    logic           r_over [0:Q];
    ljpf_pkg::t_ctx r_ctx  [0:Q];

    assign n_num = {{(NW-Q){1'b0}}, i_n} << SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q-1:0], i_vld};
        end
    end

    // quotient of 2^56 or more means clip; else the top part seeds the remainder
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_num[NW-1:Q];
        r_over[0] <= n_num[NW-1:Q] >= i_d;
        r_low[0]  <= n_num[Q-1:0];
        r_q[0]    <= '0;
        r_d[0]    <= i_d;
        r_ctx[0]  <= i_ctx;
    end

    for (genvar k = 0; k < Q; k++) begin : g_step
        logic [D:0] n_trial;
        logic       n_ge;

        always_comb begin
            n_trial = {r_rem[k], r_low[k][Q-1-k]};
            n_ge    = n_trial >= {1'b0, r_d[k]};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_ge ? D'(n_trial - {1'b0, r_d[k]}) : n_trial[D-1:0];
            r_q[k+1]    <= {r_q[k][Q-2:0], n_ge};
            r_low[k+1]  <= r_low[k];
            r_over[k+1] <= r_over[k];
            r_d[k+1]    <= r_d[k];
            r_ctx[k+1]  <= r_ctx[k];
        end
    end

    assign o_vld  = r_vld[Q];
    assign o_q    = r_over[Q] ? ljpf_pkg::STAGE_MAX : r_q[Q];
    assign o_clip = r_over[Q];
    assign o_ctx  = r_ctx[Q];

endmodule

`default_nettype wire

### sv/lennard_jones_pair_force.sv
// Top level of the Lennard-Jones 12-6 pair force pipeline.
// Depends on ljpf_pkg, ljpf_mul and ljpf_div.
//
// One pair (dx,dy,dz) is taken in every cycle; start is the only flow control, busy
// stays low. o_done stays high for one cycle per pair; the pair runs through stages 0 to 2,
// the u divider, three multipliers, stage 3, two more multipliers, the w divider, three
// force multipliers and the output register. The pipeline depth comes from the two
// restoring dividers (u = sigma^2/r2 and w = t/r2, 57 stages each, one quotient bit
// a stage) and eight two-stage 58x58 multipliers built from 29x29 partial products.
// The receiver cannot hold results off, so nothing ever stalls. Write epsilon and
// sigma only while no pair is in flight; the write port is always ready.
`default_nettype none

module lennard_jones_pair_force #(
    parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire ljpf_pkg::t_item                i_item,
    output logic                                o_done,
    output ljpf_pkg::t_result                   o_result,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ljpf_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [ljpf_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IW = ljpf_pkg::IN_W;
    localparam int Q  = ljpf_pkg::Q_W;
    localparam int W  = ljpf_pkg::MUL_W;
    localparam int CW = ljpf_pkg::CFG_W;
    localparam int RW = ljpf_pkg::R2_W;

    function automatic logic [32:0] sat_out(input logic [Q-1:0] mag, input logic neg);
        logic        clip;
        logic [31:0] m;
        if (!neg) begin
            clip = |mag[Q-1:31];
            m    = clip ? 32'h7FFF_FFFF : mag[31:0];
            return {clip, m};
        end
        clip = mag > {{(Q-32){1'b0}}, 32'h8000_0000};
        m    = clip ? 32'h8000_0000 : mag[31:0];
        return {clip, 32'(~m + 32'd1)};
    endfunction

    logic [CW-1:0] r_well_depth;
    logic [CW-1:0] r_zero_dist;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_depth <= ljpf_pkg::CFG_RESET;
            r_zero_dist  <= ljpf_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ljpf_pkg::CFG_WELL_DEPTH:    r_well_depth <= i_cfg_data;
                ljpf_pkg::CFG_ZERO_DISTANCE: r_zero_dist  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: sign and magnitude of each component
    logic                 r0_vld;
    logic [2:0][IW-1:0]   r0_mag;
    logic [2:0]           r0_neg;
    logic [2:0][IW-1:0]   n0_raw;

    assign n0_raw = {i_item.dz, i_item.dy, i_item.dx};

    // stage 1: squares; stage 2: r2 and context
    logic                 r1_vld;
    logic [2:0][RW-1:0]   r1_sq;
    logic [RW-1:0]        r1_s2;
    logic [2:0][IW-1:0]   r1_mag;
    logic [2:0]           r1_neg;

    logic                 r2_vld;
    logic [RW-1:0]        r2_s2;
    ljpf_pkg::t_ctx       r2_ctx;
    logic [RW-1:0]        n2_sum;
    ljpf_pkg::t_ctx       n2_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_neg[i] <= n0_raw[i][IW-1];
            r0_mag[i] <= n0_raw[i][IW-1] ? IW'(~n0_raw[i] + 1'b1) : n0_raw[i];
            r1_sq[i]  <= r0_mag[i] * r0_mag[i];
        end
        r1_mag <= r0_mag;
        r1_neg <= r0_neg;
        r1_s2  <= r_zero_dist * r_zero_dist;
        r2_s2  <= r1_s2;
        r2_ctx <= n2_ctx;
    end

    always_comb begin
        n2_sum      = r1_sq[0] + r1_sq[1] + r1_sq[2];
        n2_ctx      = '0;
        n2_ctx.mag  = r1_mag;
        n2_ctx.neg  = r1_neg;
        n2_ctx.r2   = n2_sum;
        n2_ctx.zero = n2_sum == '0;
    end

    // u = sigma^2 / r2
    logic           d1_vld, d1_clip;
    logic [Q-1:0]   d1_q;
    ljpf_pkg::t_ctx d1_ctx, m1_ictx;

    ljpf_div #(.SHIFT(FRAC_BITS)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_n({{(Q-RW){1'b0}}, r2_s2}), .i_d(r2_ctx.r2), .i_ctx(r2_ctx),
        .o_vld(d1_vld), .o_q(d1_q), .o_clip(d1_clip), .o_ctx(d1_ctx)
    );

    always_comb begin
        m1_ictx      = d1_ctx;
        m1_ictx.u    = d1_q;
        m1_ictx.clip = d1_ctx.clip | d1_clip;
    end

    // u^2, u^3, u^6
    logic           m1_vld, m1_clip, m2_vld, m2_clip, m3_vld, m3_clip;
    logic [Q-1:0]   m1_p, m2_p, m3_p;
    ljpf_pkg::t_ctx m1_ctx, m2_ictx, m2_ctx, m3_ictx, m3_ctx;

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(d1_vld),
        .i_a({2'b00, d1_q}), .i_b({2'b00, d1_q}), .i_ctx(m1_ictx),
        .o_vld(m1_vld), .o_p(m1_p), .o_clip(m1_clip), .o_ctx(m1_ctx)
    );

    always_comb begin
        m2_ictx      = m1_ctx;
        m2_ictx.clip = m1_ctx.clip | m1_clip;
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_u3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(m1_vld),
        .i_a({2'b00, m1_p}), .i_b({2'b00, m1_ctx.u}), .i_ctx(m2_ictx),
        .o_vld(m2_vld), .o_p(m2_p), .o_clip(m2_clip), .o_ctx(m2_ctx)
    );

    always_comb begin
        m3_ictx      = m2_ctx;
        m3_ictx.u3   = m2_p;
        m3_ictx.clip = m2_ctx.clip | m2_clip;
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_u6 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(m2_vld),
        .i_a({2'b00, m2_p}), .i_b({2'b00, m2_p}), .i_ctx(m3_ictx),
        .o_vld(m3_vld), .o_p(m3_p), .o_clip(m3_clip), .o_ctx(m3_ctx)
    );

    // stage 3: signs and magnitudes of u6-u3 and 2*u6-u3
    logic           r3_vld;
    ljpf_pkg::t_ctx r3_ctx, n3_ctx;
    logic [Q:0]     n3_u6x2, n3_u3w;

    always_comb begin
        n3_u6x2      = {m3_p, 1'b0};
        n3_u3w       = {1'b0, m3_ctx.u3};
        n3_ctx       = m3_ctx;
        n3_ctx.clip  = m3_ctx.clip | m3_clip;
        n3_ctx.eneg  = m3_p < m3_ctx.u3;
        n3_ctx.ediff = n3_ctx.eneg ? Q'(m3_ctx.u3 - m3_p) : Q'(m3_p - m3_ctx.u3);
        n3_ctx.gneg  = n3_u6x2 < n3_u3w;
        n3_ctx.gmag  = n3_ctx.gneg ? (n3_u3w - n3_u6x2) : (n3_u6x2 - n3_u3w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ctx <= n3_ctx;
    end

    // energy magnitude, then t = 24*eps*|2u6-u3|
    logic           me_vld, me_clip, mt_vld, mt_clip;
    logic [Q-1:0]   me_p, mt_p;
    logic [W-1:0]   n_eps4, n_eps24;
    ljpf_pkg::t_ctx me_ctx, mt_ictx, mt_ctx;

    always_comb begin
        n_eps4  = {{(W-CW){1'b0}}, r_well_depth} << 2;
        n_eps24 = ({{(W-CW){1'b0}}, r_well_depth} << 4)
                + ({{(W-CW){1'b0}}, r_well_depth} << 3);
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r3_vld),
        .i_a(n_eps4), .i_b({2'b00, r3_ctx.ediff}), .i_ctx(r3_ctx),
        .o_vld(me_vld), .o_p(me_p), .o_clip(me_clip), .o_ctx(me_ctx)
    );

    always_comb begin
        mt_ictx      = me_ctx;
        mt_ictx.emag = me_p;
        mt_ictx.clip = me_ctx.clip | me_clip;
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(me_vld),
        .i_a(n_eps24), .i_b({1'b0, me_ctx.gmag}), .i_ctx(mt_ictx),
        .o_vld(mt_vld), .o_p(mt_p), .o_clip(mt_clip), .o_ctx(mt_ctx)
    );

    // w = t * 2^(2F) / r2
    logic           d2_vld, d2_clip;
    logic [Q-1:0]   d2_q;
    ljpf_pkg::t_ctx d2_ictx, d2_ctx, fx_ictx;

    always_comb begin
        d2_ictx      = mt_ctx;
        d2_ictx.clip = mt_ctx.clip | mt_clip;
    end

    ljpf_div #(.SHIFT(2 * FRAC_BITS)) u_div_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(mt_vld),
        .i_n(mt_p), .i_d(mt_ctx.r2), .i_ctx(d2_ictx),
        .o_vld(d2_vld), .o_q(d2_q), .o_clip(d2_clip), .o_ctx(d2_ctx)
    );

    always_comb begin
        fx_ictx      = d2_ctx;
        fx_ictx.w    = d2_q;
        fx_ictx.clip = d2_ctx.clip | d2_clip;
    end

    // force magnitudes, one component after the other
    logic           fx_vld, fx_clip, fy_vld, fy_clip, fz_vld, fz_clip;
    logic [Q-1:0]   fx_p, fy_p, fz_p;
    ljpf_pkg::t_ctx fx_ctx, fy_ictx, fy_ctx, fz_ictx, fz_ctx;

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(d2_vld),
        .i_a({2'b00, d2_q}), .i_b({{(W-IW){1'b0}}, d2_ctx.mag[0]}), .i_ctx(fx_ictx),
        .o_vld(fx_vld), .o_p(fx_p), .o_clip(fx_clip), .o_ctx(fx_ctx)
    );

    always_comb begin
        fy_ictx        = fx_ctx;
        fy_ictx.fmag_x = fx_p;
        fy_ictx.clip   = fx_ctx.clip | fx_clip;
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(fx_vld),
        .i_a({2'b00, fx_ctx.w}), .i_b({{(W-IW){1'b0}}, fx_ctx.mag[1]}), .i_ctx(fy_ictx),
        .o_vld(fy_vld), .o_p(fy_p), .o_clip(fy_clip), .o_ctx(fy_ctx)
    );

    always_comb begin
        fz_ictx        = fy_ctx;
        fz_ictx.fmag_y = fy_p;
        fz_ictx.clip   = fy_ctx.clip | fy_clip;
    end

    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(fy_vld),
        .i_a({2'b00, fy_ctx.w}), .i_b({{(W-IW){1'b0}}, fy_ctx.mag[2]}), .i_ctx(fz_ictx),
        .o_vld(fz_vld), .o_p(fz_p), .o_clip(fz_clip), .o_ctx(fz_ctx)
    );

    // output stage: signs, saturation, zero distance override
    logic [32:0]       n_fx, n_fy, n_fz, n_en;
    ljpf_pkg::t_result n_res;

    always_comb begin
        n_fx = sat_out(fz_ctx.fmag_x, fz_ctx.gneg != fz_ctx.neg[0]);
        n_fy = sat_out(fz_ctx.fmag_y, fz_ctx.gneg != fz_ctx.neg[1]);
        n_fz = sat_out(fz_p,          fz_ctx.gneg != fz_ctx.neg[2]);
        n_en = sat_out(fz_ctx.emag,   fz_ctx.eneg);
        n_res = '0;
        if (fz_ctx.zero) begin
            n_res.too_close = 1'b1;
        end else begin
            n_res.force_x   = n_fx[31:0];
            n_res.force_y   = n_fy[31:0];
            n_res.force_z   = n_fz[31:0];
            n_res.energy    = n_en[31:0];
            n_res.saturated = fz_ctx.clip | fz_clip | n_fx[32] | n_fy[32]
                            | n_fz[32] | n_en[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= fz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_res;
    end

endmodule

`default_nettype wire

### sv/ljpf_checker.sv
// Port-level checks of the pair force pipeline, bound to the top level.
// Depends on ljpf_pkg and lennard_jones_pair_force_defines.svh.
`default_nettype none

`include "lennard_jones_pair_force_defines.svh"

module ljpf_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_done,
    input wire ljpf_pkg::t_result   o_result
);

    localparam int LAT = ljpf_pkg::LATENCY;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_warm;

    // count cycles out of reset, hold at the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != CW'(LAT)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

    `LJPF_ASSERT_RST(a_latency, i_clk, i_rst_n, (r_warm == CW'(LAT)) |-> (o_done == $past(start && !busy, LAT)), "result strobe does not match a transfer one latency earlier")
    `LJPF_ASSERT_RST(a_zero_out, i_clk, i_rst_n, (o_done && o_result.too_close) |-> (o_result.force_x == 0 && o_result.force_y == 0 && o_result.force_z == 0 && o_result.energy == 0 && !o_result.saturated), "zero distance result is not cleared")
    `LJPF_ASSERT_ALWAYS(a_no_done_in_reset, i_clk, !i_rst_n |=> !o_done, "result strobe right after reset")

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

### tb/lennard_jones_pair_force_tb.sv
// Self-checking bench for the Lennard-Jones pair force pipeline.
// Predicts every result from the displacement and the epsilon/sigma registers.
// Depends on ljpf_pkg and lennard_jones_pair_force.
`default_nettype none

module lennard_jones_pair_force_tb;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_ITEMS    = 75;

    localparam int FRAC_BITS = ljpf_pkg::FRAC_BITS;
    localparam int IN_W      = ljpf_pkg::IN_W;
    localparam int OUT_W     = ljpf_pkg::OUT_W;
    localparam int CFG_W     = ljpf_pkg::CFG_W;
    localparam int CIDX_W    = ljpf_pkg::CIDX_W;
    localparam int LATENCY   = ljpf_pkg::LATENCY;
    localparam logic [ljpf_pkg::Q_W-1:0] STAGE_MAX = ljpf_pkg::STAGE_MAX;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ljpf_pkg::t_item i_item = '0;
    logic o_done;
    ljpf_pkg::t_result o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    lennard_jones_pair_force u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Bench copy of the block's registers
    logic [CFG_W-1:0] eps_q = ljpf_pkg::CFG_RESET;
    logic [CFG_W-1:0] sigma_q = ljpf_pkg::CFG_RESET;
    bit clip_hit;

    ljpf_pkg::t_item pair_queue[$];
    ljpf_pkg::t_result pending_results[$];
    bit hold_sender = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
        if (p > {72'd0, STAGE_MAX}) begin
            clip_hit = 1'b1;
            return {8'd0, STAGE_MAX};
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] qdiv(logic [63:0] n, int sh, logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, n} << sh) / {64'd0, d};
        if (q > {72'd0, STAGE_MAX}) begin
            clip_hit = 1'b1;
            return {8'd0, STAGE_MAX};
        end
        return q[63:0];
    endfunction

    function automatic logic [OUT_W-1:0] clip_out(logic [63:0] m, bit neg);
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) begin
                clip_hit = 1'b1;
                m = 64'h7FFF_FFFF;
            end
            return m[OUT_W-1:0];
        end
        if (m > 64'h8000_0000) begin
            clip_hit = 1'b1;
            m = 64'h8000_0000;
        end
        return OUT_W'(-m);
    endfunction

    function automatic ljpf_pkg::t_result predict_pair_force(ljpf_pkg::t_item p);
        ljpf_pkg::t_result res;
        logic [23:0] raw [3];
        logic [63:0] mag [3];
        bit neg [3];
        logic [63:0] r2, u, u3, u6, emag, gmag, t, w;
        bit eneg, gneg;
        res = '0;
        raw[0] = p.dx;
        raw[1] = p.dy;
        raw[2] = p.dz;
        r2 = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = raw[i][23];
            mag[i] = neg[i] ? 64'h100_0000 - raw[i] : {40'd0, raw[i]};
            r2 += mag[i] * mag[i];
        end
        clip_hit = 1'b0;
        if (r2 == 0) begin
            res.too_close = 1'b1;
            return res;
        end
        u = qdiv({40'd0, sigma_q} * {40'd0, sigma_q}, FRAC_BITS, r2);
        u3 = qmul(qmul(u, u), u);
        u6 = qmul(u3, u3);
        eneg = u6 < u3;
        emag = qmul(4 * {40'd0, eps_q}, eneg ? u3 - u6 : u6 - u3);
        gneg = 2 * u6 < u3;
        gmag = gneg ? u3 - 2 * u6 : 2 * u6 - u3;
        t = qmul(24 * {40'd0, eps_q}, gmag);
        w = qdiv(t, 2 * FRAC_BITS, r2);
        res.force_x = clip_out(qmul(w, mag[0]), gneg != neg[0]);
        res.force_y = clip_out(qmul(w, mag[1]), gneg != neg[1]);
        res.force_z = clip_out(qmul(w, mag[2]), gneg != neg[2]);
        res.energy = clip_out(emag, eneg);
        res.saturated = clip_hit;
        return res;
    endfunction

    // Driver: send queued pairs in bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                pending_results.insert(pending_results.size(), predict_pair_force(i_item));
            if (start && busy) begin
                start <= 1'b1;  // hold the pair until it is taken
            end else if (hold_sender || pair_queue.size() == 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                start <= 1'b1;
                i_item <= pair_queue.pop_front();
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                ljpf_pkg::t_result want;
                want = pending_results.pop_front();
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [23:0] signed_mag(int lo, int hi);
        logic [23:0] m;
        m = 24'($urandom_range(lo, hi));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic ljpf_pkg::t_item mk_pair(int x, int y, int z);
        ljpf_pkg::t_item p;
        p.dx = IN_W'(x);
        p.dy = IN_W'(y);
        p.dz = IN_W'(z);
        return p;
    endfunction

    function automatic ljpf_pkg::t_item rand_pair();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)  // distances around sigma, the interesting part of the curve
            return mk_pair(signed_mag(0, 200000), signed_mag(0, 200000),
                           signed_mag(0, 200000));
        if (sel < 8)
            return mk_pair(signed_mag(0, 300), signed_mag(0, 300), signed_mag(0, 300));
        return mk_pair($urandom, $urandom, $urandom);
    endfunction

    // Append one pair to the sender's queue
    task automatic add_pair(ljpf_pkg::t_item p);
        pair_queue.insert(pair_queue.size(), p);
    endtask

    task automatic drain();
        while (pair_queue.size() != 0 || pending_results.size() != 0 || start)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ljpf_pkg::CFG_WELL_DEPTH)
            eps_q = val;
        else if (idx == ljpf_pkg::CFG_ZERO_DISTANCE)
            sigma_q = val;
    endtask

    task automatic random_phase(int n);
        repeat (n) add_pair(rand_pair());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs under reset values
        add_pair(mk_pair(0, 0, 0));
        add_pair(mk_pair(65536, 0, 0));
        add_pair(mk_pair(0, -65536, 0));
        add_pair(mk_pair(0, 0, 73562));
        add_pair(mk_pair(-73562, 0, 0));
        add_pair(mk_pair(8388607, 8388607, 8388607));
        add_pair(mk_pair(-8388608, -8388608, -8388608));
        add_pair(mk_pair(8388607, -8388608, 0));
        add_pair(mk_pair(1, 0, 0));
        add_pair(mk_pair(-1, -1, -1));
        add_pair(mk_pair(0, 0, 0));
        add_pair(mk_pair(32768, 32768, 0));
        add_pair(mk_pair(-200, 150, -100));
        add_pair(mk_pair(131072, -131072, 131072));
        add_pair(mk_pair(37837, 37837, 37837));
        add_pair(mk_pair(655360, 0, -655360));
        add_pair(mk_pair(-8388608, 1, 0));
        add_pair(mk_pair(0, 0, -1));
        random_phase(PHASE_ITEMS);

        // let part of the queue go out, then stop the sender until the pipe is empty
        while (pair_queue.size() > PHASE_ITEMS / 2) @(posedge i_clk);
        hold_sender = 1'b1;
        while (pending_results.size() != 0 || start) @(posedge i_clk);
        hold_sender = 1'b0;
        random_phase(20);

        write_reg(ljpf_pkg::CFG_WELL_DEPTH, 24'd0);
        random_phase(30);
        write_reg(ljpf_pkg::CFG_WELL_DEPTH, 24'hFF_FFFF);
        write_reg(ljpf_pkg::CFG_ZERO_DISTANCE, 24'hFF_FFFF);
        add_pair(mk_pair(8388607, 8388607, 8388607));
        random_phase(PHASE_ITEMS);
        write_reg(ljpf_pkg::CFG_ZERO_DISTANCE, 24'd0);
        random_phase(40);
        write_reg(ljpf_pkg::CFG_WELL_DEPTH, CFG_W'($urandom));
        write_reg(ljpf_pkg::CFG_ZERO_DISTANCE, CFG_W'($urandom));
        random_phase(PHASE_ITEMS);
        // unused register indexes must leave both registers alone
        write_reg(CIDX_W'(2), CFG_W'($urandom));
        write_reg(CIDX_W'(3), CFG_W'($urandom));
        random_phase(40);
        write_reg(ljpf_pkg::CFG_WELL_DEPTH, 24'd16384);
        write_reg(ljpf_pkg::CFG_ZERO_DISTANCE, 24'd98304);
        random_phase(PHASE_ITEMS);

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
